### rtl/gdsb_pkg.sv
package gdsb_pkg;

    localparam int MAX_GRID_WIDTH_DEF = 512;

    localparam int PIX_W   = 8;
    localparam int GRAY_W  = 7;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 9;
    localparam int SUM_W   = 12;
    localparam int IDX_W   = 1;
    localparam int CFG_W   = 9;
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 48;

    localparam int SHADOW_SHIFT = 4;
    localparam int CENTER_SHIFT = 3;

    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    localparam logic [IDX_W-1:0] REG_BITMAP_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_SHADOW_ENABLE = 1'b1;

endpackage

### rtl/gdsb_line_store.sv
module gdsb_line_store #(
    parameter int DEPTH = gdsb_pkg::MAX_GRID_WIDTH_DEF,
    parameter int AW    = $clog2(gdsb_pkg::MAX_GRID_WIDTH_DEF)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [gdsb_pkg::PIX_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [gdsb_pkg::PIX_W-1:0] rd_data
);

    logic [gdsb_pkg::PIX_W-1:0] mem [DEPTH];
    logic [gdsb_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/glyph_drop_shadow_blur.sv
// path: an accepted request is held in stage 1, then in the result register on m_axis
// throughput: one pixel per cycle unless m_axis stalls, set by the registered read
// of the line stores that feeds the window sum one stage after the request is taken
// reset: aresetn synchronous, clears handshake state, counters, window taps and
// config (bitmap_width 1, shadow off); line store contents are not cleared
module glyph_drop_shadow_blur #(
    parameter int MAX_GRID_WIDTH = gdsb_pkg::MAX_GRID_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [gdsb_pkg::S_DATA_W-1:0] s_axis_tdata,   // pixel_alpha
    input  logic [gdsb_pkg::S_USER_W-1:0] s_axis_tuser,   // glyph_start
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // glyph_alpha, shadow_alpha, backing_gray, column, row, zero pad
    output logic [gdsb_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [gdsb_pkg::IDX_W-1:0]    cfg_addr,
    input  logic [gdsb_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int AW = $clog2(MAX_GRID_WIDTH);
    localparam int XW = ((AW > gdsb_pkg::COL_W) ? AW : gdsb_pkg::COL_W) + 1;
    localparam int PW = gdsb_pkg::PIX_W;
    localparam int SW = gdsb_pkg::SUM_W;
    localparam int PAD_W = gdsb_pkg::M_DATA_W - 2 * PW - gdsb_pkg::GRAY_W
                           - gdsb_pkg::COL_W - gdsb_pkg::ROW_W;

    // config
    logic [gdsb_pkg::COL_W-1:0] bw_reg;
    logic                       en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_reg <= gdsb_pkg::COL_W'(1);
            en_reg <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_addr == gdsb_pkg::REG_BITMAP_WIDTH) begin
                bw_reg <= cfg_wdata[gdsb_pkg::COL_W-1:0];
            end
            if (cfg_addr == gdsb_pkg::REG_SHADOW_ENABLE) begin
                en_reg <= cfg_wdata[0];
            end
        end
    end

    // grid position
    logic [gdsb_pkg::COL_W-1:0] col_reg, col_in;
    logic [gdsb_pkg::ROW_W-1:0] row_reg, row_in;
    logic [gdsb_pkg::COL_W-1:0] bw_eff;
    logic [XW-1:0]              gw_raw, gw, col_x, col_inc;
    logic                       wrap, in_store_in, s_acc, adv1;
    logic [AW-1:0]              addr_in;

    assign bw_eff      = (bw_reg == '0) ? gdsb_pkg::COL_W'(1) : bw_reg;
    assign gw_raw      = XW'(bw_eff) + XW'(en_reg);
    assign gw          = (gw_raw > XW'(MAX_GRID_WIDTH)) ? XW'(MAX_GRID_WIDTH) : gw_raw;
    assign col_in      = s_axis_tuser[0] ? '0 : col_reg;
    assign row_in      = s_axis_tuser[0] ? '0 : row_reg;
    assign col_x       = XW'(col_in);
    assign col_inc     = col_x + XW'(1);
    assign wrap        = (col_inc >= gw);
    assign in_store_in = (col_x < XW'(MAX_GRID_WIDTH));
    assign addr_in     = col_x[AW-1:0];
    assign s_acc       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_acc) begin
            if (wrap) begin
                col_reg <= '0;
                if (row_in != gdsb_pkg::ROW_MAX) begin
                    row_reg <= row_in + gdsb_pkg::ROW_W'(1);
                end else begin
                    row_reg <= row_in;
                end
            end else begin
                col_reg <= col_in + gdsb_pkg::COL_W'(1);
                row_reg <= row_in;
            end
        end
    end

    // stage 1: line store read data arrives
    logic                       s1_vld_reg;
    logic [PW-1:0]              s1_cur_reg;
    logic [gdsb_pkg::COL_W-1:0] s1_col_reg;
    logic [gdsb_pkg::ROW_W-1:0] s1_row_reg;
    logic                       s1_in_store_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic                       fwd_reg;
    logic [PW-1:0]              fwd_a_reg, fwd_b_reg;
    logic                       out_vld_reg;
    logic [gdsb_pkg::M_DATA_W-1:0] out_data_reg;
    logic [PW-1:0]              rd_a, rd_b, raw_a0, raw_b0;
    logic                       fwd_next;

    assign adv1          = s1_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !s1_vld_reg || adv1;
    assign fwd_next      = adv1 && s1_in_store_reg && in_store_in && (s1_addr_reg == addr_in);

    assign raw_a0 = !s1_in_store_reg ? '0 : (fwd_reg ? fwd_a_reg : rd_a);
    assign raw_b0 = !s1_in_store_reg ? '0 : (fwd_reg ? fwd_b_reg : rd_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (s_acc) begin
            s1_vld_reg <= 1'b1;
        end else if (adv1) begin
            s1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_cur_reg      <= s_axis_tdata[PW-1:0];
            s1_col_reg      <= col_in;
            s1_row_reg      <= row_in;
            s1_in_store_reg <= in_store_in;
            s1_addr_reg     <= addr_in;
            fwd_reg         <= fwd_next;
            fwd_a_reg       <= s1_cur_reg;
            fwd_b_reg       <= raw_a0;
        end
    end

    gdsb_line_store #(
        .DEPTH (MAX_GRID_WIDTH),
        .AW    (AW)
    ) u_store_above (
        .aclk    (aclk),
        .wr_en   (adv1 && s1_in_store_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_cur_reg),
        .rd_en   (s_acc),
        .rd_addr (addr_in),
        .rd_data (rd_a)
    );

    gdsb_line_store #(
        .DEPTH (MAX_GRID_WIDTH),
        .AW    (AW)
    ) u_store_two_above (
        .aclk    (aclk),
        .wr_en   (adv1 && s1_in_store_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (raw_a0),
        .rd_en   (s_acc),
        .rd_addr (addr_in),
        .rd_data (rd_b)
    );

    // window taps
    logic [PW-1:0] left1_reg, left2_reg, up_l1_reg, up_l2_reg, up2_l1_reg, up2_l2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left1_reg  <= '0;
            left2_reg  <= '0;
            up_l1_reg  <= '0;
            up_l2_reg  <= '0;
            up2_l1_reg <= '0;
            up2_l2_reg <= '0;
        end else if (adv1) begin
            left1_reg  <= s1_cur_reg;
            left2_reg  <= left1_reg;
            up_l1_reg  <= raw_a0;
            up_l2_reg  <= up_l1_reg;
            up2_l1_reg <= raw_b0;
            up2_l2_reg <= up2_l1_reg;
        end
    end

    // window sum
    logic                       c_gt0, c_gt1, r_gt0, r_gt1, shadow_on;
    logic [PW-1:0]              l1, l2, a0, a1, a2, b0, b1, b2;
    logic [SW-1:0]              sum;
    logic [PW-1:0]              shadow;
    logic [gdsb_pkg::GRAY_W-1:0] gray;

    assign c_gt0 = (s1_col_reg != '0);
    assign c_gt1 = (s1_col_reg > gdsb_pkg::COL_W'(1));
    assign r_gt0 = (s1_row_reg != '0);
    assign r_gt1 = (s1_row_reg > gdsb_pkg::ROW_W'(1));

    assign l1 = c_gt0 ? left1_reg : '0;
    assign l2 = c_gt1 ? left2_reg : '0;
    assign a0 = r_gt0 ? raw_a0 : '0;
    assign a1 = (r_gt0 && c_gt0) ? up_l1_reg : '0;
    assign a2 = (r_gt0 && c_gt1) ? up_l2_reg : '0;
    assign b0 = r_gt1 ? raw_b0 : '0;
    assign b1 = (r_gt1 && c_gt0) ? up2_l1_reg : '0;
    assign b2 = (r_gt1 && c_gt1) ? up2_l2_reg : '0;

    assign sum = SW'(s1_cur_reg) + SW'(l1) + SW'(l2) + SW'(a0) + SW'(a2)
               + SW'(b0) + SW'(b1) + SW'(b2) + (SW'(a1) << gdsb_pkg::CENTER_SHIFT);

    assign shadow_on = en_reg && (c_gt0 || r_gt0);
    assign shadow    = shadow_on ? PW'(sum >> gdsb_pkg::SHADOW_SHIFT) : '0;
    assign gray      = shadow_on ? s1_cur_reg[PW-1:1] : '0;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv1) begin
            out_vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            out_data_reg <= {PAD_W'(0), s1_row_reg, s1_col_reg, gray, shadow, s1_cur_reg};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // checks
    a_adv_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv1 |=> out_vld_reg)
        else $error("stage advance did not load result register");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_vld_reg && !adv1) |=> (s1_vld_reg && $stable(s1_cur_reg) && $stable(s1_col_reg)))
        else $error("stalled stage lost its request");

    a_origin_no_shadow: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_data_reg[31:23] == '0 && out_data_reg[40:32] == '0)
        |-> (out_data_reg[22:8] == '0))
        else $error("shadow or gray nonzero at origin");

endmodule

### dv/glyph_drop_shadow_blur_tb.sv
module glyph_drop_shadow_blur_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX     = gdsb_pkg::MAX_GRID_WIDTH_DEF;
    localparam int GRID_AW      = $clog2(GRID_MAX);
    localparam int FILL_COLS    = 64;
    localparam int RANDOM_ITEMS = 600;

    typedef struct packed {
        logic [gdsb_pkg::PIX_W-1:0] alpha;
        logic                       start;
    } pixel_req_t;

    typedef struct packed {
        logic [gdsb_pkg::PIX_W-1:0]  glyph_alpha;
        logic [gdsb_pkg::PIX_W-1:0]  shadow_alpha;
        logic [gdsb_pkg::GRAY_W-1:0] backing_gray;
        logic [gdsb_pkg::COL_W-1:0]  column;
        logic [gdsb_pkg::ROW_W-1:0]  row;
    } shaded_px_t;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [gdsb_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [gdsb_pkg::S_USER_W-1:0] s_axis_tuser  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [gdsb_pkg::M_DATA_W-1:0] m_axis_tdata;
    logic                          cfg_we        = 1'b0;
    logic [gdsb_pkg::IDX_W-1:0]    cfg_addr      = gdsb_pkg::REG_BITMAP_WIDTH;
    logic [gdsb_pkg::CFG_W-1:0]    cfg_wdata     = '0;

    glyph_drop_shadow_blur #(
        .MAX_GRID_WIDTH(GRID_MAX)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    pixel_req_t pixel_q[$];
    shaded_px_t shaded_px_q[$];
    int         mismatch_count = 0;
    int         items_sent     = 0;
    bit         req_taken      = 1'b0;
    int         burst_left     = 0;
    int         gap_left       = 0;
    int         gap_max        = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  rx_slot       = '0;

    // blur predictor state
    logic [gdsb_pkg::PIX_W-1:0] line_above [GRID_MAX];
    logic [gdsb_pkg::PIX_W-1:0] line_two_above [GRID_MAX];
    logic [gdsb_pkg::PIX_W-1:0] prev_px = '0, prev2_px = '0;
    logic [gdsb_pkg::PIX_W-1:0] above_l1 = '0, above_l2 = '0;
    logic [gdsb_pkg::PIX_W-1:0] two_above_l1 = '0, two_above_l2 = '0;
    int unsigned      col_pos = 0, row_pos = 0;
    int unsigned      width_reg = 1, shadow_reg = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("glyph_drop_shadow_blur regression: fail");
        $finish;
    end

    function automatic int unsigned grid_cols();
        int unsigned w;
        w = (width_reg == 0) ? 1 : width_reg;
        w += shadow_reg;
        if (w > GRID_MAX) w = GRID_MAX;
        return w;
    endfunction

    function automatic shaded_px_t blur_predict(input logic [gdsb_pkg::PIX_W-1:0] px,
                                                input logic first);
        shaded_px_t                 res;
        logic [gdsb_pkg::PIX_W-1:0] up0, up2_0, t_l1, t_l2, t_a0, t_a1, t_a2;
        logic [gdsb_pkg::PIX_W-1:0] t_b0, t_b1, t_b2;
        logic [GRID_AW-1:0]         ci;
        int unsigned                c, r, total;
        if (first) begin
            col_pos = 0;
            row_pos = 0;
        end
        c  = col_pos;
        r  = row_pos;
        ci = c[GRID_AW-1:0];
        up0   = line_above[ci];
        up2_0 = line_two_above[ci];
        t_l1 = (c > 0) ? prev_px : '0;
        t_l2 = (c > 1) ? prev2_px : '0;
        t_a0 = (r > 0) ? up0 : '0;
        t_a1 = (r > 0 && c > 0) ? above_l1 : '0;
        t_a2 = (r > 0 && c > 1) ? above_l2 : '0;
        t_b0 = (r > 1) ? up2_0 : '0;
        t_b1 = (r > 1 && c > 0) ? two_above_l1 : '0;
        t_b2 = (r > 1 && c > 1) ? two_above_l2 : '0;

        res.glyph_alpha  = px;
        res.shadow_alpha = '0;
        res.backing_gray = '0;
        res.column       = c[gdsb_pkg::COL_W-1:0];
        res.row          = r[gdsb_pkg::ROW_W-1:0];
        if (shadow_reg != 0 && (c != 0 || r != 0)) begin
            total = px + t_l1 + t_l2 + t_a0 + t_a2 + t_b0 + t_b1 + t_b2
                    + (t_a1 << gdsb_pkg::CENTER_SHIFT);
            res.shadow_alpha = gdsb_pkg::PIX_W'(total >> gdsb_pkg::SHADOW_SHIFT);
            res.backing_gray = px[gdsb_pkg::PIX_W-1:1];
        end

        above_l2     = above_l1;
        above_l1     = up0;
        two_above_l2 = two_above_l1;
        two_above_l1 = up2_0;
        prev2_px     = prev_px;
        prev_px      = px;
        line_two_above[ci] = up0;
        line_above[ci]     = px;

        if (c + 1 >= grid_cols()) begin
            col_pos = 0;
            if (r < gdsb_pkg::ROW_MAX) row_pos = r + 1;
        end else begin
            col_pos = c + 1;
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatch_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // result check, then prediction for the request taken at this edge
    always @(posedge aclk) begin
        shaded_px_t want;
        req_taken = 1'b0;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (shaded_px_q.size() == 0) begin
                    flag_mismatch("unexpected result", m_axis_tdata[15:0], '0);
                end else begin
                    want = shaded_px_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.glyph_alpha)
                        flag_mismatch("glyph_alpha", 16'(m_axis_tdata[7:0]),
                                      16'(want.glyph_alpha));
                    if (m_axis_tdata[15:8] !== want.shadow_alpha)
                        flag_mismatch("shadow_alpha", 16'(m_axis_tdata[15:8]),
                                      16'(want.shadow_alpha));
                    if (m_axis_tdata[22:16] !== want.backing_gray)
                        flag_mismatch("backing_gray", 16'(m_axis_tdata[22:16]),
                                      16'(want.backing_gray));
                    if (m_axis_tdata[31:23] !== want.column)
                        flag_mismatch("column", 16'(m_axis_tdata[31:23]), 16'(want.column));
                    if (m_axis_tdata[40:32] !== want.row)
                        flag_mismatch("row", 16'(m_axis_tdata[40:32]), 16'(want.row));
                    if (m_axis_tdata[47:41] !== '0)
                        flag_mismatch("pad bits", 16'(m_axis_tdata[47:41]), '0);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req_taken = 1'b1;
                want = blur_predict(s_axis_tdata, s_axis_tuser[0]);
                shaded_px_q = {shaded_px_q, want};
                void'(pixel_q.pop_front());
            end
        end
    end

    // request driver and result-side stall pattern
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_q[0].alpha;
                s_axis_tuser  <= pixel_q[0].start;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= stall_pattern[rx_slot];
        rx_slot       <= rx_slot + 1'b1;
    end

    task automatic push_px(input logic [gdsb_pkg::PIX_W-1:0] a, input logic st);
        pixel_req_t p;
        p.alpha = a;
        p.start = st;
        pixel_q = {pixel_q, p};
        items_sent++;
    endtask

    function automatic logic [gdsb_pkg::PIX_W-1:0] rand_alpha();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return gdsb_pkg::PIX_W'($urandom_range(0, 255));
    endfunction

    // one glyph over the extended grid, pad positions mostly zero
    task automatic load_glyph(input int cols, input int rows, input bit sh,
                              input bit fresh, input int drop);
        int                         k, c, r;
        logic [gdsb_pkg::PIX_W-1:0] a;
        bit                         pad;
        for (k = 0; k < cols * rows - drop; k++) begin
            c   = k % cols;
            r   = k / cols;
            pad = sh && (c == cols - 1 || r == rows - 1);
            a   = (pad && $urandom_range(0, 19) != 0) ? '0 : rand_alpha();
            push_px(a, (fresh && k == 0) || $urandom_range(0, 199) == 0);
        end
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || shaded_px_q.size() != 0 || s_axis_tvalid)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [gdsb_pkg::IDX_W-1:0] idx,
                             input logic [gdsb_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == gdsb_pkg::REG_BITMAP_WIDTH) width_reg = val;
        else shadow_reg = val[0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input int w, input int sh);
        if ($urandom_range(0, 1) == 0) begin
            write_reg(gdsb_pkg::REG_BITMAP_WIDTH, gdsb_pkg::CFG_W'(w));
            write_reg(gdsb_pkg::REG_SHADOW_ENABLE, gdsb_pkg::CFG_W'(sh));
        end else begin
            write_reg(gdsb_pkg::REG_SHADOW_ENABLE, gdsb_pkg::CFG_W'(sh));
            write_reg(gdsb_pkg::REG_BITMAP_WIDTH, gdsb_pkg::CFG_W'(w));
        end
    endtask

    initial begin
        int w, rows, nglyph, base, pick, cols, drop, g;
        bit fresh, wide_done;
        wide_done = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // two rows over the narrow grid range so carried-on glyphs find written entries
        set_config(FILL_COLS - 1, 1);
        gap_max       = 3;
        stall_pattern = 16'hB6DB;
        for (int k = 0; k < 2 * FILL_COLS; k++) push_px(rand_alpha(), k == 0);
        wait_idle();

        // saturated window, pad filled too, then a restart mid-glyph
        set_config(3, 1);
        gap_max       = 0;
        stall_pattern = 16'hFFFF;
        for (int k = 0; k < 16; k++) push_px(8'hFF, k == 0);
        push_px(8'h00, 1'b1);
        push_px(8'h01, 1'b0);
        push_px(8'h80, 1'b0);
        push_px(8'h7F, 1'b0);
        push_px(8'hAA, 1'b0);
        push_px(8'h55, 1'b1);
        push_px(8'hFE, 1'b0);
        push_px(8'hFF, 1'b0);
        wait_idle();

        // zero width, shadow off: one column, row runs into saturation
        set_config(0, 0);
        push_px(rand_alpha(), 1'b1);
        for (int k = 0; k < 514; k++) push_px(rand_alpha(), 1'b0);
        wait_idle();

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 39);
            if (pick == 0) w = 0;
            else if (pick == 1 && !wide_done) w = 511;
            else if (pick == 2 && !wide_done) w = $urandom_range(256, 510);
            else w = $urandom_range(1, 12);
            if (w > FILL_COLS || grid_cols() > FILL_COLS || $urandom_range(0, 4) != 0)
                set_config(w, $urandom_range(0, 1));
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 2) == 0) begin
                stall_pattern = 16'hFFFF;
            end else begin
                stall_pattern = 16'($urandom());
                if (stall_pattern == '0) stall_pattern[0] = 1'b1;
            end
            cols   = grid_cols();
            nglyph = (cols > FILL_COLS) ? 1 : $urandom_range(1, 4);
            // a narrow phase may carry on the glyph of the last one under a new width
            fresh  = (cols > FILL_COLS) || $urandom_range(0, 5) != 0;
            for (g = 0; g < nglyph; g++) begin
                if (cols > FILL_COLS) begin
                    // one full row, then the start of the second
                    rows      = 2;
                    drop      = cols - $urandom_range(2, 16);
                    wide_done = 1'b1;
                end else begin
                    rows = $urandom_range(1, 6) + shadow_reg;
                    drop = ($urandom_range(0, 5) == 0) ? $urandom_range(1, cols - 1 + 1) - 1 : 0;
                end
                load_glyph(cols, rows, shadow_reg[0], fresh || g > 0, drop);
            end
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && shaded_px_q.size() == 0) begin
            $display("glyph_drop_shadow_blur regression: pass");
        end else begin
            $display("glyph_drop_shadow_blur regression: fail");
        end
        $finish;
    end

endmodule
